/* rtl/nla_pkg.sv */
package nla_pkg;

   localparam int COORD_W = 16;
   localparam int TAG_W = 16;
   localparam int SQ_W = 32;
   localparam int DIST_W = 33;
   localparam int OP_W = 2;

   localparam int TABLE_DEPTH_DEFAULT = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_APPEND,
      KIND_QUERY
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic [TAG_W-1:0]           tag;
   } cmd_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic [TAG_W-1:0]           tag;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } eng_state_type;

endpackage

/* rtl/nla_front.sv */
module nla_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [nla_pkg::OP_W-1:0]      req_op,
   input  logic [nla_pkg::COORD_W-1:0]   req_x,
   input  logic [nla_pkg::COORD_W-1:0]   req_y,
   input  logic [nla_pkg::TAG_W-1:0]     req_tag,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output nla_pkg::cmd_type              cmd
);
   import nla_pkg::*;

   cmd_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    fill_ff, fill_in;
   cmd_type              decoded;
   logic                 keep;
   logic                 push;
   logic                 pop;

   // classify the incoming word; unused codes are dropped here
   always_comb begin
      decoded.x = $signed(req_x);
      decoded.y = $signed(req_y);
      decoded.tag = req_tag;
      decoded.kind = KIND_CLEAR;
      keep = 1'b1;
      case (req_op)
         OP_CLEAR: begin
            decoded.kind = KIND_CLEAR;
         end
         OP_APPEND: begin
            decoded.kind = KIND_APPEND;
         end
         OP_QUERY: begin
            decoded.kind = KIND_QUERY;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign push = req_tvalid && req_tready && keep;
   assign pop = cmd_valid && cmd_ready;
   assign cmd_valid = (fill_ff != '0);
   assign cmd = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

/* rtl/nla_back.sv */
module nla_back #(
   parameter int TABLE_DEPTH = nla_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  nla_pkg::cmd_type              cmd,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          rsp_found,
   output logic [nla_pkg::TAG_W-1:0]     rsp_tag,
   output logic [nla_pkg::DIST_W-1:0]    rsp_dist
);
   import nla_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   entry_type                  mem [TABLE_DEPTH];
   entry_type                  rd_data_ff;
   logic                       wr_en;
   logic                       rd_en;

   eng_state_type              state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           issue_ff, issue_in;
   logic signed [COORD_W-1:0]  qx_ff, qx_in;
   logic signed [COORD_W-1:0]  qy_ff, qy_in;
   logic                       start;

   logic                       s1_valid_ff;
   logic                       s2_valid_ff;
   logic [SQ_W-1:0]            sq_x_ff;
   logic [SQ_W-1:0]            sq_y_ff;
   logic [TAG_W-1:0]           s2_tag_ff;
   logic signed [COORD_W:0]    dx;
   logic signed [COORD_W:0]    dy;
   logic [COORD_W:0]           ax;
   logic [COORD_W:0]           ay;
   logic [DIST_W-1:0]          dist_sum;

   logic                       best_found_ff;
   logic [DIST_W-1:0]          best_dist_ff;
   logic [TAG_W-1:0]           best_tag_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff;
   logic [TAG_W-1:0]           rsp_tag_ff;
   logic [DIST_W-1:0]          rsp_dist_ff;
   logic                       load;

   // sequencer: clear and append finish in the idle state, a query scans the table
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      issue_in = issue_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      cmd_ready = 1'b0;
      wr_en = 1'b0;
      rd_en = 1'b0;
      start = 1'b0;
      load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               case (cmd.kind)
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  KIND_APPEND: begin
                     if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        wr_en = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_QUERY: begin
                     qx_in = cmd.x;
                     qy_in = cmd.y;
                     issue_in = '0;
                     start = 1'b1;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               rd_en = 1'b1;
               issue_in = issue_ff + 1'b1;
            end else if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= '{x: cmd.x, y: cmd.y, tag: cmd.tag};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[issue_ff[ADDR_W-1:0]];
      end
   end

   // distance per axis; magnitudes fit in 16 bits
   always_comb begin
      dx = $signed({qx_ff[COORD_W-1], qx_ff}) - $signed({rd_data_ff.x[COORD_W-1], rd_data_ff.x});
      dy = $signed({qy_ff[COORD_W-1], qy_ff}) - $signed({rd_data_ff.y[COORD_W-1], rd_data_ff.y});
      ax = dx[COORD_W] ? $unsigned(-dx) : $unsigned(dx);
      ay = dy[COORD_W] ? $unsigned(-dy) : $unsigned(dy);
      dist_sum = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         sq_x_ff <= ax[COORD_W-1:0] * ax[COORD_W-1:0];
         sq_y_ff <= ay[COORD_W-1:0] * ay[COORD_W-1:0];
         s2_tag_ff <= rd_data_ff.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         best_found_ff <= 1'b0;
         best_dist_ff <= '0;
         best_tag_ff <= '0;
      end else if (s2_valid_ff && (!best_found_ff || dist_sum < best_dist_ff)) begin
         best_found_ff <= 1'b1;
         best_dist_ff <= dist_sum;
         best_tag_ff <= s2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_found_ff <= best_found_ff;
         rsp_tag_ff <= best_tag_ff;
         rsp_dist_ff <= best_dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         issue_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff <= qx_in;
      qy_ff <= qy_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_tag = rsp_tag_ff;
   assign rsp_dist = rsp_dist_ff;

endmodule

/* rtl/nearest_landmark_association.sv */
// Nearest landmark association. Words on the request stream clear the landmark
// table, append one landmark (x, y, tag; ignored once TABLE_DEPTH entries are
// held) or query the landmark nearest to an observed point. Only a query
// produces a response word: found, the tag of the first entry in table order
// with the least squared distance, and that distance (1/1024 m^2 units);
// found, tag and distance are all zero on an empty table. Operation code 3 is
// dropped without a response. Requests enter a four-word command queue, so the
// request side keeps accepting while the engine works. Clear and append are
// handled in the engine's idle state. A query of a table of N entries reads the
// single-port table memory one entry per cycle, then a read, square and compare
// pipeline drains and the response register loads.
// The response register holds a finished word while the next query scans.
module nearest_landmark_association #(
   parameter int TABLE_DEPTH = nla_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // point_x[15:0], point_y[31:16], landmark_tag[47:32]
   input  logic [1:0]   req_tuser,   // operation[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,   // matched_tag[15:0], best_distance_squared[48:16], zeros
   output logic [0:0]   rsp_tuser    // found[0]
);
   import nla_pkg::*;

   logic                 cmd_valid;
   logic                 cmd_ready;
   cmd_type              cmd;
   logic                 found;
   logic [TAG_W-1:0]     matched_tag;
   logic [DIST_W-1:0]    best_distance_squared;

   // decode and queue request words
   nla_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_x      (req_tdata[15:0]),
      .req_y      (req_tdata[31:16]),
      .req_tag    (req_tdata[47:32]),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   // hold the table, scan it on a query, register the response
   nla_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_found  (found),
      .rsp_tag    (matched_tag),
      .rsp_dist   (best_distance_squared)
   );

   // pack the response word, padded to whole bytes
   assign rsp_tdata = {7'd0, best_distance_squared, matched_tag};
   assign rsp_tuser = found;

endmodule

/* test/landmark_match_checker.sv */
module landmark_match_checker #(
   parameter int TABLE_DEPTH = nla_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // point_x[15:0], point_y[31:16], landmark_tag[47:32]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,   // matched_tag[15:0], best_distance_squared[48:16], zeros
   input  logic [0:0]  rsp_tuser,   // found[0]
   output int          mismatch_count,
   output int          pending_count
);
   import nla_pkg::*;

   typedef struct {
      logic              found;
      logic [TAG_W-1:0]  tag;
      logic [DIST_W-1:0] distance;
   } answer_type;

   entry_type   landmark_table [TABLE_DEPTH];
   int          landmark_total;
   answer_type  pending_answers [$];

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, field, got, want);
      mismatch_count++;
   endtask

   // Scan in table order; only a strictly smaller distance replaces the best so far.
   function automatic answer_type nearest_entry(logic signed [COORD_W-1:0] px,
                                                logic signed [COORD_W-1:0] py);
      answer_type best;
      longint     dx;
      longint     dy;
      longint     d;
      best = '{found: 1'b0, tag: '0, distance: '0};
      for (int i = 0; i < landmark_total; i++) begin
         dx = longint'(px) - longint'(landmark_table[i].x);
         dy = longint'(py) - longint'(landmark_table[i].y);
         d  = dx * dx + dy * dy;
         if (!best.found || d < best.distance) begin
            best.found    = 1'b1;
            best.tag      = landmark_table[i].tag;
            best.distance = d[DIST_W-1:0];
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         landmark_total = 0;
         mismatch_count = 0;
         pending_answers.delete();
      end else begin
         // Check the response first: a query taken at this edge cannot be answered yet.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("unrequested response word", 64'(rsp_tdata), '0);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tuser[0] !== want.found)
                  report_mismatch("found", 64'(rsp_tuser), 64'(want.found));
               if (rsp_tdata[15:0] !== want.tag)
                  report_mismatch("matched_tag", 64'(rsp_tdata[15:0]), 64'(want.tag));
               if (rsp_tdata[48:16] !== want.distance)
                  report_mismatch("best_distance_squared", 64'(rsp_tdata[48:16]),
                                  64'(want.distance));
               if (rsp_tdata[55:49] !== '0)
                  report_mismatch("zero padding", 64'(rsp_tdata[55:49]), '0);
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_CLEAR: begin
                  landmark_total = 0;
               end
               OP_APPEND: begin
                  if (landmark_total < TABLE_DEPTH) begin
                     landmark_table[landmark_total] = '{x: req_tdata[15:0],
                                                        y: req_tdata[31:16],
                                                        tag: req_tdata[47:32]};
                     landmark_total++;
                  end
               end
               OP_QUERY: begin
                  pending_answers.insert(pending_answers.size(),
                                         nearest_entry(req_tdata[15:0], req_tdata[31:16]));
               end
               default: begin
               end
            endcase
         end
      end
      pending_count = pending_answers.size();
   end

endmodule

/* test/tb.sv */
module tb;
   import nla_pkg::*;

   // The package names no code for the unused operation; the block drops it.
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   localparam int DEPTH           = TABLE_DEPTH_DEFAULT;
   localparam int RANDOM_WORDS    = 800;
   localparam int CALM_TAIL       = 120;   // words at the end sent with no idling
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int QUIET_LIMIT     = 4000;  // cycles with no word moving on either side
   localparam int DRAIN_CYCLES    = 100;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // point_x[15:0], point_y[31:16], landmark_tag[47:32]
   logic [1:0]  req_tuser;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // matched_tag[15:0], best_distance_squared[48:16], zeros
   logic [0:0]  rsp_tuser;   // found[0]

   int          mismatch_count;
   int          pending_count;
   int          quiet_cycles;
   int          useful_words;
   bit          idling_on;
   bit          hold_off_request;
   point_type   placed [$];   // landmarks the block holds, used to aim queries

   nearest_landmark_association #(
      .TABLE_DEPTH (DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   landmark_match_checker #(
      .TABLE_DEPTH (DEPTH)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial clock = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort when nothing moves for too long; a correct run never stalls this long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: mostly ready, short random stalls, and one long hold-off on request.
   initial begin
      bit hold_off_done;
      hold_off_done = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_request && !hold_off_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_done = 1'b1;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Mix extremes, a tight cluster around the origin and the full range.
   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2, 3: return COORD_W'(int'($urandom_range(0, 64)) - 32);
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // Aim most queries close to a held landmark so near ties and small distances occur.
   function automatic point_type aimed_point();
      point_type p;
      int        k;
      if (placed.size() != 0 && $urandom_range(0, 2) != 0) begin
         k = $urandom_range(0, placed.size() - 1);
         p.x = COORD_W'(int'(placed[k].x) + int'($urandom_range(0, 8)) - 4);
         p.y = COORD_W'(int'(placed[k].y) + int'($urandom_range(0, 8)) - 4);
      end else begin
         p.x = random_coord();
         p.y = random_coord();
      end
      return p;
   endfunction

   // Offer one word from a falling edge, hold it until taken, return at a falling edge.
   task automatic send_word(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y, logic [TAG_W-1:0] tag);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {tag, y, x};
      do @(posedge clock); while (!req_tready);
      // Track the table to aim queries; dropped words do not count as work.
      case (op)
         OP_CLEAR: begin
            placed.delete();
            useful_words++;
         end
         OP_APPEND: begin
            if (placed.size() < DEPTH) begin
               placed.insert(placed.size(), '{x: x, y: y});
               useful_words++;
            end
         end
         OP_QUERY: begin
            useful_words++;
         end
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   initial begin
      point_type p;
      int        n;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = OP_CLEAR;
      idling_on        = 1'b1;
      hold_off_request = 1'b0;
      useful_words     = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, dropped code, extremes, ties, clear.
      send_word(OP_QUERY, 16'sh0000, 16'sh0000, 16'h0000);
      send_word(OP_RESERVED, 16'sh7fff, 16'shffff, 16'hffff);
      send_word(OP_APPEND, 16'sh8000, 16'sh8000, 16'hffff);
      send_word(OP_QUERY, 16'sh7fff, 16'sh7fff, 16'h0000);   // largest distance
      send_word(OP_QUERY, 16'sh8000, 16'sh8000, 16'h0000);   // zero distance
      send_word(OP_APPEND, 16'sh7fff, 16'sh7fff, 16'h0000);
      send_word(OP_APPEND, 16'sh0000, 16'sh0000, 16'h1234);
      send_word(OP_APPEND, 16'sh0000, 16'sh0000, 16'h5678);  // duplicate point
      send_word(OP_APPEND, 16'sh0002, 16'sh0000, 16'haaaa);
      send_word(OP_QUERY, 16'sh0000, 16'sh0000, 16'hffff);   // equal distance, keep earlier
      send_word(OP_QUERY, 16'sh0001, 16'sh0000, 16'h0000);   // equidistant neighbors
      send_word(OP_QUERY, 16'sh7fff, 16'sh8000, 16'h0000);
      send_word(OP_QUERY, 16'shffff, 16'shffff, 16'h0000);
      send_word(OP_CLEAR, 16'sh7fff, 16'sh8000, 16'hffff);
      send_word(OP_QUERY, 16'sh7fff, 16'sh7fff, 16'h0000);   // empty after clear
      send_word(OP_APPEND, 16'shffff, 16'sh7fff, 16'h8000);
      send_word(OP_QUERY, 16'sh7fff, 16'shffff, 16'h0000);

      // Fill a sizable table, then block the response side while queries keep coming.
      send_word(OP_CLEAR, '0, '0, '0);
      repeat (40) send_word(OP_APPEND, random_coord(), random_coord(), TAG_W'($urandom));
      hold_off_request = 1'b1;
      repeat (20) begin
         p = aimed_point();
         send_word(OP_QUERY, p.x, p.y, TAG_W'($urandom));
      end

      // Random: mostly build-then-query runs, some noise and half-built runs.
      while (useful_words < RANDOM_WORDS) begin
         if (useful_words > RANDOM_WORDS - CALM_TAIL)
            idling_on = 1'b0;
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(1, 4))
                  send_word(OP_W'($urandom_range(0, 3)), COORD_W'($urandom),
                            COORD_W'($urandom), TAG_W'($urandom));
            end
            1: begin
               // Query with no fresh landmarks, often right after a clear.
               if ($urandom_range(0, 1) == 0)
                  send_word(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                            TAG_W'($urandom));
               repeat ($urandom_range(1, 3)) begin
                  p = aimed_point();
                  send_word(OP_QUERY, p.x, p.y, TAG_W'($urandom));
               end
            end
            default: begin
               if ($urandom_range(0, 2) != 0)
                  send_word(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                            TAG_W'($urandom));
               // Now and then run past the table depth to hit the full-table drop.
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
               repeat (n)
                  send_word(OP_APPEND, random_coord(), random_coord(), TAG_W'($urandom));
               repeat ($urandom_range(1, 6)) begin
                  p = aimed_point();
                  send_word(OP_QUERY, p.x, p.y, TAG_W'($urandom));
                  if ($urandom_range(0, 4) == 0)
                     send_word(OP_APPEND, random_coord(), random_coord(), TAG_W'($urandom));
               end
            end
         endcase
      end

      // Drop valid, drain the outstanding answers, then watch for stray words.
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
